@@ rtl/core/kth_pkg.sv @@
`default_nettype none
package kth_pkg;

   localparam int SLOT_BITS_DEF = 10;
   localparam int HASH_BITS = 16;
   localparam int KEY_BITS = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [KEY_BITS-1:0] KEY_EMPTY = 32'd0;
   localparam logic [KEY_BITS-1:0] KEY_GONE = 32'd1;

   typedef enum logic [1:0] {
      MODE_FIND = 2'd0,
      MODE_ADD = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_FOUND = 3'd0,
      STAT_ADDED = 3'd1,
      STAT_MISSING = 3'd2,
      STAT_REMOVED = 3'd3,
      STAT_CLEARED = 3'd4,
      STAT_FULL = 3'd5,
      STAT_RESERVED = 3'd6
   } status_type;

   typedef struct packed {
      mode_type mode;
      logic reserved;
      logic [KEY_BITS-1:0] key;
      logic [HASH_BITS-1:0] first;
      logic [HASH_BITS-1:0] step;
   } item_type;

   function automatic logic [HASH_BITS-1:0] first_hash(input logic [KEY_BITS-1:0] key);
      logic [KEY_BITS-1:0] h;
      h = key;
      for (int k = 1; k <= 12; k++) begin
         h = h ^ KEY_BITS'($signed(key) >>> (5 * k));
      end
      return h[HASH_BITS-1:0];
   endfunction

   function automatic logic [HASH_BITS-1:0] step_hash(input logic [KEY_BITS-1:0] key);
      logic [KEY_BITS-1:0] d;
      d = key;
      for (int k = 1; k <= 9; k++) begin
         d = d ^ KEY_BITS'($signed(key) >>> (7 * k));
      end
      return {d[HASH_BITS-1:1], 1'b1};
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/key_to_index_hash_table.sv @@
// Find, add and remove probe the slot memory until they hit the key, an empty slot or the probe
// limit; a reserved key is answered without a probe, and a clear sweeps all 2^SLOT_BITS slots.
// Throughput: one word at a time in the back end, a probe per cycle on the slot memory port.
// Reset sweeps the slot memory empty with req_tready low.
// The free list and the index fields need no clearing.
`default_nettype none
module key_to_index_hash_table #(
   parameter int SLOT_BITS = kth_pkg::SLOT_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [39:0] req_tdata, // mode, key
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [((SLOT_BITS + 10) / 8) * 8 - 1:0] rsp_tdata // index, status
);

   logic init_busy, item_valid, item_pop;
   kth_pkg::item_type item;
   logic [SLOT_BITS-1:0] rsp_index;
   kth_pkg::status_type rsp_status;

   kth_front front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .init_busy(init_busy), .item_valid(item_valid),
      .item_pop(item_pop), .item(item)
   );

   kth_back #(.SLOT_BITS(SLOT_BITS)) back (
      .clock(clock), .reset(reset), .item_valid(item_valid), .item_pop(item_pop),
      .item(item), .init_busy(init_busy), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_index(rsp_index), .rsp_status(rsp_status)
   );

   assign rsp_tdata = $bits(rsp_tdata)'({rsp_status, rsp_index});

endmodule
`default_nettype wire

@@ rtl/core/kth_ram.sv @@
`default_nettype none
module kth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/kth_front.sv @@
`default_nettype none
module kth_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [39:0] req_tdata,
   input wire logic init_busy,
   output logic item_valid,
   input wire logic item_pop,
   output kth_pkg::item_type item
);

   localparam int PTR_BITS = $clog2(kth_pkg::QUEUE_DEPTH);

   kth_pkg::item_type queue_ff [kth_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0] fill_ff;
   kth_pkg::item_type new_item;
   logic push;
   logic [31:0] key;

   assign key = req_tdata[33:2];
   assign req_tready = (fill_ff != (PTR_BITS+1)'(kth_pkg::QUEUE_DEPTH)) && !init_busy;
   assign push = req_tvalid && req_tready;

   always_comb begin
      new_item.mode = kth_pkg::mode_type'(req_tdata[1:0]);
      new_item.key = key;
      new_item.reserved = (key == kth_pkg::KEY_EMPTY) || (key == kth_pkg::KEY_GONE);
      new_item.first = kth_pkg::first_hash(key);
      new_item.step = kth_pkg::step_hash(key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (item_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(item_pop);
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign item_valid = (fill_ff != '0);
   assign item = queue_ff[rd_ptr_ff];

endmodule
`default_nettype wire

@@ rtl/core/kth_back.sv @@
`default_nettype none
module kth_back #(
   parameter int SLOT_BITS = kth_pkg::SLOT_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic item_valid,
   output logic item_pop,
   input wire kth_pkg::item_type item,
   output logic init_busy,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [SLOT_BITS-1:0] rsp_index,
   output kth_pkg::status_type rsp_status
);

   localparam int NSLOTS = 1 << SLOT_BITS;
   localparam int HALF = 1 << (SLOT_BITS - 1);
   localparam int SW = kth_pkg::KEY_BITS + SLOT_BITS;
   localparam logic [SLOT_BITS-1:0] HALF_V = SLOT_BITS'(HALF);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PROBE, S_EMIT} state_type;

   state_type state_ff;
   logic init_ff;
   kth_pkg::mode_type mode_ff;
   logic [31:0] key_ff;
   logic [SLOT_BITS-1:0] slot_ff, step_ff, cnt_ff, gone_ff, clr_ff;
   logic gone_vld_ff;
   logic [SLOT_BITS-1:0] free_cnt_ff, next_idx_ff, esl_ff;
   logic [SLOT_BITS-1:0] res_index_ff;
   kth_pkg::status_type res_status_ff;
   logic out_vld_ff;
   logic [SLOT_BITS-1:0] out_index_ff;
   kth_pkg::status_type out_status_ff;

   logic slot_we;
   logic [SLOT_BITS-1:0] slot_wa, slot_ra;
   logic [SW-1:0] slot_wd, slot_rd;
   logic fs_we;
   logic [SLOT_BITS-2:0] fs_wa;
   logic [SLOT_BITS-1:0] fs_wd, fs_rd;
   logic [SLOT_BITS-2:0] fs_rd_addr;
   logic [SLOT_BITS-1:0] fs_top;
   logic [31:0] rd_key;
   logic [SLOT_BITS-1:0] rd_idx, next_slot, gone_now, alloc_idx;
   logic gone_now_vld;

   assign rd_key = slot_rd[SW-1:SLOT_BITS];
   assign rd_idx = slot_rd[SLOT_BITS-1:0];
   assign next_slot = slot_ff + step_ff;
   assign slot_ra = (state_ff == S_IDLE) ? item.first[SLOT_BITS-1:0] : next_slot;
   assign gone_now_vld = gone_vld_ff || (rd_key == kth_pkg::KEY_GONE);
   assign gone_now = gone_vld_ff ? gone_ff : slot_ff;
   assign alloc_idx = (free_cnt_ff != '0) ? fs_rd : SLOT_BITS'(next_idx_ff + 1'b1);
   assign item_pop = (state_ff == S_IDLE) && item_valid;
   assign init_busy = init_ff;

   kth_ram #(.WIDTH(SW), .DEPTH(NSLOTS)) slot_ram (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(slot_wd),
      .rd_addr(slot_ra), .rd_data(slot_rd)
   );

   kth_ram #(.WIDTH(SLOT_BITS), .DEPTH(HALF)) free_ram (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_addr(fs_rd_addr), .rd_data(fs_rd)
   );

   assign fs_top = free_cnt_ff - 1'b1;
   assign fs_rd_addr = fs_top[SLOT_BITS-2:0];
   assign fs_wa = free_cnt_ff[SLOT_BITS-2:0];
   assign fs_wd = rd_idx;

   always_comb begin
      slot_we = 1'b0;
      slot_wa = slot_ff;
      slot_wd = {kth_pkg::KEY_EMPTY, rd_idx};
      fs_we = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_ff;
         end
         S_PROBE: begin
            if (rd_key == key_ff) begin
               if (mode_ff == kth_pkg::MODE_REMOVE) begin
                  slot_we = 1'b1;
                  slot_wd = {kth_pkg::KEY_GONE, rd_idx};
                  fs_we = (free_cnt_ff < HALF_V);
               end
            end else if (mode_ff == kth_pkg::MODE_ADD) begin
               if (rd_key == kth_pkg::KEY_EMPTY) begin
                  if (gone_vld_ff || esl_ff != '0) begin
                     slot_we = 1'b1;
                     slot_wa = gone_vld_ff ? gone_ff : slot_ff;
                     slot_wd = {key_ff, alloc_idx};
                  end
               end else if ((&cnt_ff) && gone_now_vld) begin
                  slot_we = 1'b1;
                  slot_wa = gone_now;
                  slot_wd = {key_ff, alloc_idx};
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         init_ff <= 1'b1;
         clr_ff <= '0;
         free_cnt_ff <= '0;
         next_idx_ff <= '0;
         esl_ff <= HALF_V;
         out_vld_ff <= 1'b0;
      end else begin
         if (out_vld_ff && rsp_tready && state_ff != S_EMIT) begin
            out_vld_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (&clr_ff) begin
                  free_cnt_ff <= '0;
                  next_idx_ff <= '0;
                  esl_ff <= HALF_V;
                  res_index_ff <= '0;
                  res_status_ff <= kth_pkg::STAT_CLEARED;
                  init_ff <= 1'b0;
                  state_ff <= init_ff ? S_IDLE : S_EMIT;
               end
            end
            S_IDLE: begin
               if (item_valid) begin
                  mode_ff <= item.mode;
                  key_ff <= item.key;
                  slot_ff <= item.first[SLOT_BITS-1:0];
                  step_ff <= item.step[SLOT_BITS-1:0];
                  cnt_ff <= '0;
                  gone_vld_ff <= 1'b0;
                  res_index_ff <= '0;
                  if (item.mode == kth_pkg::MODE_CLEAR) begin
                     clr_ff <= '0;
                     state_ff <= S_CLEAR;
                  end else if (item.reserved) begin
                     res_status_ff <= kth_pkg::STAT_RESERVED;
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_PROBE;
                  end
               end
            end
            S_PROBE: begin
               if (rd_key == key_ff) begin
                  res_index_ff <= rd_idx;
                  if (mode_ff == kth_pkg::MODE_REMOVE) begin
                     res_status_ff <= kth_pkg::STAT_REMOVED;
                     if (free_cnt_ff < HALF_V) begin
                        free_cnt_ff <= free_cnt_ff + 1'b1;
                     end
                  end else begin
                     res_status_ff <= kth_pkg::STAT_FOUND;
                  end
                  state_ff <= S_EMIT;
               end else if (rd_key == kth_pkg::KEY_EMPTY || (&cnt_ff)) begin
                  state_ff <= S_EMIT;
                  if (mode_ff != kth_pkg::MODE_ADD) begin
                     res_status_ff <= kth_pkg::STAT_MISSING;
                  end else if (slot_we) begin
                     res_status_ff <= kth_pkg::STAT_ADDED;
                     res_index_ff <= alloc_idx;
                     if (free_cnt_ff != '0) begin
                        free_cnt_ff <= free_cnt_ff - 1'b1;
                     end else begin
                        next_idx_ff <= alloc_idx;
                     end
                     if (rd_key == kth_pkg::KEY_EMPTY && !gone_vld_ff) begin
                        esl_ff <= esl_ff - 1'b1;
                     end
                  end else begin
                     res_status_ff <= kth_pkg::STAT_FULL;
                  end
               end else begin
                  gone_ff <= gone_now;
                  gone_vld_ff <= gone_now_vld;
                  cnt_ff <= cnt_ff + 1'b1;
                  slot_ff <= next_slot;
               end
            end
            S_EMIT: begin
               if (!out_vld_ff || rsp_tready) begin
                  out_vld_ff <= 1'b1;
                  out_index_ff <= res_index_ff;
                  out_status_ff <= res_status_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_index = out_index_ff;
   assign rsp_status = out_status_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= HALF_V) else $error("free count above half the slots");
   a_esl_bound: assert property (@(posedge clock) disable iff (reset)
      esl_ff <= HALF_V) else $error("empty slot budget above half the slots");
   a_init_clear: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> state_ff == S_CLEAR) else $error("item taken during initial sweep");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> state_ff != S_IDLE) else $error("popped word not taken up");

endmodule
`default_nettype wire
